// File: design/rot_pkg.sv
// shared constants for the reference counted object table
package rot_pkg;

   // default table depth
   localparam int TABLE_ENTRIES_DEFAULT = 32;

   // field widths
   localparam int REQ_W    = 2;
   localparam int DEV_W    = 8;
   localparam int OBJ_W    = 16;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;
   localparam int REFS_W   = 16;

   // one stored entry: device, object, count
   localparam int ENTRY_W = DEV_W + OBJ_W + REFS_W;

   // request codes
   localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PUT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CLAIMED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LAST    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd5;

   // saturation point of a count
   localparam logic [REFS_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

// File: design/refcounted_object_table.sv
// Reference counted object table: get by device and object, dup and put by slot.
// A get scans the entries in order, reading one table entry a cycle from the ram, and a
// match ends the scan early; dup and put read the named slot directly, and rejected
// requests go straight to the reply step; any item waits while the result side stalls.
// One item at a time: the next is accepted only once the result of the last is loaded.
// Reset clears all per-entry valid bits at once, so every count reads zero; no clearing pass.
module refcounted_object_table #(
   parameter int TABLE_ENTRIES = rot_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rot_pkg::REQ_W-1:0]     req_type,
   input  logic [rot_pkg::DEV_W-1:0]     req_device_id,
   input  logic [rot_pkg::OBJ_W-1:0]     req_object_number,
   input  logic [rot_pkg::SLOT_W-1:0]    req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rot_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [rot_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rot_pkg::REFS_W-1:0]    rsp_ref_count_out
);
   import rot_pkg::*;

   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = AW + 1;
   localparam int WSL_W = AW + SLOT_W;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_REPLY  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [REQ_W-1:0]         op_ff, op_in;
   logic [DEV_W-1:0]         dev_ff, dev_in;
   logic [OBJ_W-1:0]         obj_ff, obj_in;
   logic [CNT_W-1:0]         rd_cnt_ff, rd_cnt_in;
   logic [AW-1:0]            chk_ff, chk_in;
   logic                     pend_ff, pend_in;
   logic                     hit_ff, hit_in;
   logic                     free_ff, free_in;
   logic [AW-1:0]            tgt_ff, tgt_in;
   logic [REFS_W-1:0]        hit_refs_ff, hit_refs_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [REFS_W-1:0]        res_refs_ff, res_refs_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [REFS_W-1:0]        rsp_refs_ff, rsp_refs_in;

   logic                     accept;
   logic [WSL_W-1:0]         slot_wide;
   logic                     slot_in_range;
   logic                     scan_issue;
   logic                     ram_rd_en;
   logic [AW-1:0]            ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic                     ram_wr_en;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic [REFS_W-1:0]        entry_refs;
   logic                     entry_match;
   logic [REFS_W-1:0]        cur_refs;
   logic                     out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // slot number widened so the range check works at any table depth
   assign slot_wide     = WSL_W'(req_slot_index);
   assign slot_in_range = slot_wide < WSL_W'(TABLE_ENTRIES);

   // one entry read a cycle during a scan, or the named slot at acceptance
   assign scan_issue  = (state_ff == S_SCAN) && (rd_cnt_ff < CNT_W'(TABLE_ENTRIES));
   assign ram_rd_en   = scan_issue ||
                        (accept && slot_in_range &&
                         (req_type == REQ_DUP || req_type == REQ_PUT));
   assign ram_rd_addr = scan_issue ? rd_cnt_ff[AW-1:0] : slot_wide[AW-1:0];

   // shared entry compare: an entry never written reads as free
   assign entry_refs  = valid_ff[chk_ff] ? ram_rd_data[REFS_W-1:0] : '0;
   assign entry_match = pend_ff && (entry_refs != '0) &&
                        (ram_rd_data[ENTRY_W-1 -: DEV_W] == dev_ff) &&
                        (ram_rd_data[REFS_W +: OBJ_W] == obj_ff);

   // count of the target entry at the update step
   always_comb begin
      if (op_ff == REQ_GET) begin
         cur_refs = hit_ff ? hit_refs_ff : '0;
      end else begin
         cur_refs = valid_ff[tgt_ff] ? ram_rd_data[REFS_W-1:0] : '0;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      dev_in        = dev_ff;
      obj_in        = obj_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      hit_in        = hit_ff;
      free_in       = free_ff;
      tgt_in        = tgt_ff;
      hit_refs_in   = hit_refs_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_refs_in   = res_refs_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_refs_in   = rsp_refs_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = {dev_ff, obj_ff, cur_refs};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_type;
               dev_in = req_device_id;
               obj_in = req_object_number;
               if (req_type == REQ_GET) begin
                  state_in  = S_SCAN;
                  rd_cnt_in = '0;
                  hit_in    = 1'b0;
                  free_in   = 1'b0;
               end else if (req_type == REQ_DUP || req_type == REQ_PUT) begin
                  if (slot_in_range) begin
                     state_in = S_UPDATE;
                     tgt_in   = slot_wide[AW-1:0];
                  end else begin
                     state_in      = S_REPLY;
                     res_slot_in   = req_slot_index;
                     res_status_in = ST_ERROR;
                     res_refs_in   = '0;
                  end
               end else begin
                  state_in      = S_REPLY;
                  res_slot_in   = '0;
                  res_status_in = ST_ERROR;
                  res_refs_in   = '0;
               end
            end
         end
         S_SCAN: begin
            // read stage
            if (scan_issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               chk_in    = rd_cnt_ff[AW-1:0];
               pend_in   = 1'b1;
            end
            // compare stage, a match ends the scan
            if (entry_match) begin
               hit_in      = 1'b1;
               tgt_in      = chk_ff;
               hit_refs_in = entry_refs;
               state_in    = S_UPDATE;
            end else if (pend_ff) begin
               if (!free_ff && entry_refs == '0) begin
                  free_in = 1'b1;
                  tgt_in  = chk_ff;
               end
               if (chk_ff == AW'(TABLE_ENTRIES - 1)) begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            state_in    = S_REPLY;
            res_slot_in = SLOT_W'(tgt_ff);
            if (op_ff == REQ_GET) begin
               if (hit_ff) begin
                  if (cur_refs == COUNT_MAX) begin
                     res_status_in = ST_ERROR;
                     res_refs_in   = COUNT_MAX;
                  end else begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = {dev_ff, obj_ff, cur_refs + REFS_W'(1)};
                     res_status_in = ST_HIT;
                     res_refs_in   = cur_refs + REFS_W'(1);
                  end
               end else if (free_ff) begin
                  ram_wr_en        = 1'b1;
                  ram_wr_data      = {dev_ff, obj_ff, REFS_W'(1)};
                  valid_in[tgt_ff] = 1'b1;
                  res_status_in    = ST_CLAIMED;
                  res_refs_in      = REFS_W'(1);
               end else begin
                  res_slot_in   = '0;
                  res_status_in = ST_FULL;
                  res_refs_in   = '0;
               end
            end else if (cur_refs == '0) begin
               res_status_in = ST_ERROR;
               res_refs_in   = '0;
            end else if (op_ff == REQ_DUP) begin
               if (cur_refs == COUNT_MAX) begin
                  res_status_in = ST_ERROR;
                  res_refs_in   = COUNT_MAX;
               end else begin
                  ram_wr_en     = 1'b1;
                  ram_wr_data   = {ram_rd_data[ENTRY_W-1:REFS_W], cur_refs + REFS_W'(1)};
                  res_status_in = ST_DONE;
                  res_refs_in   = cur_refs + REFS_W'(1);
               end
            end else begin
               // put: entry stays valid and becomes free at zero
               ram_wr_en     = 1'b1;
               ram_wr_data   = {ram_rd_data[ENTRY_W-1:REFS_W], cur_refs - REFS_W'(1)};
               res_status_in = (cur_refs == REFS_W'(1)) ? ST_LAST : ST_DONE;
               res_refs_in   = cur_refs - REFS_W'(1);
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_refs_in   = res_refs_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dev_ff        <= dev_in;
      obj_ff        <= obj_in;
      rd_cnt_ff     <= rd_cnt_in;
      chk_ff        <= chk_in;
      hit_ff        <= hit_in;
      free_ff       <= free_in;
      tgt_ff        <= tgt_in;
      hit_refs_ff   <= hit_refs_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_refs_ff   <= res_refs_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_refs_ff   <= rsp_refs_in;
   end

   // entry store
   rot_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_ref_count_out = rsp_refs_ff;

   // an accepted item blocks the next one in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted while previous item in flight");

   // a result only appears from the reply step
   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_REPLY)
      else $error("result loaded outside reply step");

   // table is never read past its last entry, and is written only in the update step
   a_ram_in_range: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en |-> ram_rd_addr < AW'(TABLE_ENTRIES - 1) || ram_rd_addr == AW'(TABLE_ENTRIES - 1))
      and (ram_wr_en |-> state_ff == S_UPDATE))
      else $error("table access out of range or out of step");

   // a claimed entry is marked valid afterwards
   a_claim_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && op_ff == REQ_GET && !hit_ff && free_ff)
      |=> valid_ff[$past(tgt_ff)])
      else $error("claimed entry not marked valid");

endmodule

// File: design/rot_ram.sv
// generic single write, single read ram with registered read data
module rot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb.sv
// testbench for the reference counted object table: shadow table, random requests, checks
`timescale 1ns / 100ps

module tb;
   import rot_pkg::*;

   localparam int NUM_SLOTS = TABLE_ENTRIES_DEFAULT;
   localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 517;
   localparam int MODE_SPAN = 60;
   localparam int KEY_POOL = 40;
   localparam int HOLD_CYCLES = 300;

   // request modes for the random part
   localparam int MODE_FILL = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [DEV_W-1:0]  dev;
      logic [OBJ_W-1:0]  obj;
      logic [SLOT_W-1:0] slot;
   } request_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic [REFS_W-1:0]   count;
   } outcome_type;

   // shadow copy of the table and the outcomes still owed by the block
   class table_scoreboard;
      logic [DEV_W-1:0]  dev_of[NUM_SLOTS];
      logic [OBJ_W-1:0]  obj_of[NUM_SLOTS];
      logic [REFS_W-1:0] refs_of[NUM_SLOTS];
      outcome_type owed_outcomes[$];
      int failures;

      function new();
         foreach (refs_of[i]) begin
            refs_of[i] = '0;
            dev_of[i] = '0;
            obj_of[i] = '0;
         end
         failures = 0;
      endfunction

      // work out the outcome of one request and update the shadow table
      function outcome_type apply_request(request_type r);
         outcome_type o;
         bit found;
         bit have_free;
         int hit_slot;
         int free_slot;
         logic [REFS_W-1:0] c;
         o = '{slot: '0, status: ST_ERROR, count: '0};
         found = 0;
         have_free = 0;
         hit_slot = 0;
         free_slot = 0;
         case (r.kind)
            REQ_GET: begin
               // full scan: a match past a free entry still counts
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!found && refs_of[i] != 0 && dev_of[i] == r.dev && obj_of[i] == r.obj) begin
                     found = 1;
                     hit_slot = i;
                  end
                  if (!have_free && refs_of[i] == 0) begin
                     have_free = 1;
                     free_slot = i;
                  end
               end
               if (found) begin
                  o.slot = hit_slot[SLOT_W-1:0];
                  if (refs_of[hit_slot] == COUNT_MAX) begin
                     o.count = COUNT_MAX;
                  end else begin
                     refs_of[hit_slot] = refs_of[hit_slot] + 1'b1;
                     o.status = ST_HIT;
                     o.count = refs_of[hit_slot];
                  end
               end else if (!have_free) begin
                  o.status = ST_FULL;
               end else begin
                  dev_of[free_slot] = r.dev;
                  obj_of[free_slot] = r.obj;
                  refs_of[free_slot] = REFS_W'(1);
                  o.slot = free_slot[SLOT_W-1:0];
                  o.status = ST_CLAIMED;
                  o.count = REFS_W'(1);
               end
            end
            REQ_DUP, REQ_PUT: begin
               c = refs_of[r.slot];
               o.slot = r.slot;
               // a free slot is flagged and left alone
               if (c == 0) begin
                  o.status = ST_ERROR;
               end else if (r.kind == REQ_DUP) begin
                  if (c == COUNT_MAX) begin
                     o.count = COUNT_MAX;
                  end else begin
                     refs_of[r.slot] = c + 1'b1;
                     o.status = ST_DONE;
                     o.count = refs_of[r.slot];
                  end
               end else begin
                  refs_of[r.slot] = c - 1'b1;
                  o.status = (refs_of[r.slot] == 0) ? ST_LAST : ST_DONE;
                  o.count = refs_of[r.slot];
               end
            end
            default: begin
               o.status = ST_ERROR;
            end
         endcase
         return o;
      endfunction

      function void note_request(request_type r);
         owed_outcomes.push_back(apply_request(r));
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (owed_outcomes.size() == 0) begin
            $error("result with nothing owed: slot_out %0d status %0d ref_count_out %0d",
                   got.slot, got.status, got.count);
            failures++;
            return;
         end
         want = owed_outcomes.pop_front();
         if (got.slot !== want.slot) begin
            $error("slot_out: expected %0d, actual %0d", want.slot, got.slot);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.count !== want.count) begin
            $error("ref_count_out: expected %0d, actual %0d", want.count, got.count);
            failures++;
         end
      endfunction

      // a random live slot, or -1 when the table is empty
      function int live_slot();
         int live[$];
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (refs_of[i] != 0) live.push_back(i);
         end
         if (live.size() == 0) return -1;
         return live[$urandom_range(live.size() - 1)];
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type;
   logic [DEV_W-1:0]    req_device_id;
   logic [OBJ_W-1:0]    req_object_number;
   logic [SLOT_W-1:0]   req_slot_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [STATUS_W-1:0] rsp_status;
   logic [REFS_W-1:0]   rsp_ref_count_out;

   table_scoreboard sb;
   logic [DEV_W-1:0] pool_dev[KEY_POOL];
   logic [OBJ_W-1:0] pool_obj[KEY_POOL];
   int send_idle;
   int recv_idle;
   int hold_request;
   int hold_left;
   int quiet_cycles;
   bit took;

   refcounted_object_table DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_device_id     (req_device_id),
      .req_object_number (req_object_number),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_status        (rsp_status),
      .rsp_ref_count_out (rsp_ref_count_out)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // result side: random stalls, with a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         took = 0;
         if (req_valid && !req_stall) begin
            sb.note_request('{kind: req_type, dev: req_device_id, obj: req_object_number,
                              slot: req_slot_index});
            took = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_outcome('{slot: rsp_slot_out, status: rsp_status,
                               count: rsp_ref_count_out});
            took = 1;
         end
         quiet_cycles <= took ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // offer one item, called just after a falling edge; returns once it is accepted
   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_device_id <= r.dev;
      req_object_number <= r.obj;
      req_slot_index <= r.slot;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic issue(logic [REQ_W-1:0] kind, logic [DEV_W-1:0] dev,
                        logic [OBJ_W-1:0] obj, logic [SLOT_W-1:0] slot);
      @(negedge clock);
      send_request('{kind: kind, dev: dev, obj: obj, slot: slot});
   endtask

   task automatic wait_drained();
      while (sb.owed_outcomes.size() != 0) @(posedge clock);
   endtask

   // random request, mostly well formed, weighted by the current mode
   function automatic request_type pick_request(int mode);
      request_type r;
      int roll;
      int get_pct;
      int dup_pct;
      int k;
      int s;
      r.kind = REQ_PUT;
      r.dev = DEV_W'($urandom);
      r.obj = OBJ_W'($urandom);
      r.slot = SLOT_W'($urandom);
      get_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 15 : 45;
      dup_pct = (mode == MODE_MIXED) ? 20 : 8;
      roll = $urandom_range(99);
      if (roll < 3) begin
         r.kind = REQ_BAD;
      end else if (roll < 3 + get_pct) begin
         r.kind = REQ_GET;
         if ($urandom_range(9) != 0) begin
            k = $urandom_range(KEY_POOL - 1);
            r.dev = pool_dev[k];
            r.obj = pool_obj[k];
         end
      end else begin
         if (roll < 3 + get_pct + dup_pct) r.kind = REQ_DUP;
         s = sb.live_slot();
         if (s >= 0 && $urandom_range(99) < 85) r.slot = s[SLOT_W-1:0];
      end
      return r;
   endfunction

   task automatic run_random(int count);
      int mode;
      request_type r;
      mode = MODE_MIXED;
      for (int i = 0; i < count; i++) begin
         if (i % MODE_SPAN == 0) mode = $urandom_range(2);
         @(negedge clock);
         r = pick_request(mode);
         send_request(r);
      end
   endtask

   // stimulus
   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_GET;
      req_device_id = '0;
      req_object_number = '0;
      req_slot_index = '0;
      send_idle = 0;
      recv_idle = 0;
      hold_request = 0;
      quiet_cycles = 0;
      foreach (pool_dev[i]) begin
         pool_dev[i] = DEV_W'($urandom);
         pool_obj[i] = OBJ_W'($urandom);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 32;
      recv_idle = 73;

      // directed: claims, hit past a free entry, dup and put, free-slot and unknown requests
      issue(REQ_GET, 8'h00, 16'h0000, 5'd0);
      issue(REQ_GET, 8'hFF, 16'hFFFF, 5'd31);
      issue(REQ_PUT, 8'h00, 16'h0000, 5'd0);
      issue(REQ_GET, 8'hFF, 16'hFFFF, 5'd0);
      issue(REQ_GET, 8'h00, 16'h0000, 5'd31);
      issue(REQ_GET, 8'h00, 16'h0000, 5'd0);
      issue(REQ_DUP, 8'hFF, 16'hFFFF, 5'd0);
      issue(REQ_PUT, 8'h00, 16'h0000, 5'd0);
      issue(REQ_DUP, 8'h00, 16'h0000, 5'd9);
      issue(REQ_PUT, 8'hFF, 16'hFFFF, 5'd31);
      issue(REQ_BAD, 8'hFF, 16'hFFFF, 5'd31);
      issue(REQ_BAD, 8'h00, 16'h0000, 5'd0);
      issue(REQ_PUT, 8'h00, 16'h0000, 5'd1);
      issue(REQ_PUT, 8'h00, 16'h0000, 5'd1);
      issue(REQ_GET, 8'h5A, 16'hA5A5, 5'd0);
      issue(REQ_DUP, 8'h00, 16'h0000, 5'd1);

      run_random(PHASE_ITEMS);

      send_idle = 73;
      recv_idle = 32;
      run_random(PHASE_ITEMS);

      // no idling, and a long hold-off on the result side to back the block up
      send_idle = 0;
      recv_idle = 0;
      hold_request = HOLD_CYCLES;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.owed_outcomes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
